### design/sbg_pkg.sv
// Streebog hash engine: shared constants and the LPS round function.
// Holds the S-box, the linear map rows and the round constants.
// No dependencies.
package sbg_pkg;

   localparam int ROUNDS     = 12;
   localparam int BLOCK_BITS = 512;
   localparam int STEP_W     = 5;
   localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(2 * ROUNDS + 1);

   localparam logic [7:0] SBOX [256] = '{
      8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
      8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
      8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
      8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
      8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
      8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
      8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
      8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
      8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
      8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
      8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
      8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
      8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
      8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
      8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
      8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
      8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
      8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
      8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
      8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
      8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
      8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
      8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
      8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
      8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
      8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
      8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
      8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
      8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
      8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
      8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
      8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182};

   // row r is selected by input bit 63-r
   localparam logic [63:0] LMAT [64] = '{
      64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
      64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
      64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
      64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
      64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
      64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
      64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
      64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
      64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
      64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
      64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
      64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
      64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
      64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
      64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
      64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083};

   // most significant 64-bit word first
   localparam logic [511:0] RCONST [ROUNDS] = '{
      {64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
       64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
      {64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
       64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
      {64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
       64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
      {64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
       64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
      {64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
       64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
      {64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
       64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
      {64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
       64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
      {64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
       64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
      {64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
       64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
      {64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
       64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
      {64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
       64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
      {64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
       64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}};

   function automatic logic [511:0] sbg_lps(input logic [511:0] w);
      logic [511:0] t;
      logic [63:0]  v;
      logic [63:0]  r;
      t = '0;
      for (int i = 0; i < 8; i++) begin
         for (int k = 0; k < 8; k++) begin
            v[8*k +: 8] = SBOX[w[64*k + 8*i +: 8]];
         end
         r = '0;
         for (int b = 0; b < 64; b++) begin
            if (v[b]) begin
               r = r ^ LMAT[63-b];
            end
         end
         t[64*i +: 64] = r;
      end
      return t;
   endfunction

endpackage

### design/streebog_hash_engine_unit.sv
// Streebog hash engine (GOST R 34.11-2012), 512/256-bit digest.
// Top level: word packing, padding, sequencer and the shared LPS unit.
// Depends on sbg_pkg.
//
// Usage: message words come in on req_ (tdata = data_bytes, byte_count;
// tlast marks the final word). Bytes gather into 64-byte blocks; each full
// block is compressed by one LPS unit shared by key and state, one LPS per
// cycle. A word is accepted, then stored; one that fills a block is
// accepted, stored, compressed, then given a second store pass.
// On the last word the block is padded and three compressions follow
// (pad, N, Sigma) before the first digest word; when that word also
// fills a block, that full block is compressed before the padding.
// The digest leaves on rsp_ as 8 words (csr_digest_mode 0) or the upper
// 4 words (mode 1), least significant first, tlast on the final one.
// req_tready is high only while the sequencer is idle; an unread final
// digest word may sit in the output register while the next message starts.
// A stalled receiver holds the output register and the sequencer waits.
// Reset (synchronous, active high) clears mode, state and output valid.
// The user must write csr_digest_mode only between messages; the block does not enforce this.
module streebog_hash_engine_unit
   import sbg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // data_bytes[63:0], byte_count[67:64], zero pad
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // digest_word[63:0], word_index[66:64], zero pad
   output logic        rsp_tlast
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PUT  = 3'd1;
   localparam logic [2:0] ST_PAD  = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [1:0] JOB_BLK  = 2'd0;
   localparam logic [1:0] JOB_PAD  = 2'd1;
   localparam logic [1:0] JOB_FINN = 2'd2;
   localparam logic [1:0] JOB_FINS = 2'd3;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   job_ff, job_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic         mode_ff, mode_in;
   logic         in_msg_ff, in_msg_in;
   logic [6:0]   fill_ff, fill_in;
   logic [63:0]  hold_ff, hold_in;
   logic [3:0]   rem_ff, rem_in;
   logic         last_ff, last_in;
   logic [511:0] cv_ff, cv_in;
   logic [511:0] n_ff, n_in;
   logic [511:0] s_ff, s_in;
   logic [511:0] buf_ff, buf_in;
   logic [511:0] m_ff, m_in;
   logic [511:0] k_ff, k_in;
   logic [511:0] st_ff, st_in;
   logic [3:0]   ocnt_ff, ocnt_in;
   logic         ovld_ff, ovld_in;
   logic [63:0]  oword_ff, oword_in;
   logic [2:0]   oidx_ff, oidx_in;
   logic         olast_ff, olast_in;

   logic [511:0] lps_arg, lps_res, padded, n_sum, cv_fin;
   logic [3:0]   cnt_sat, nput, nw;
   logic [6:0]   room;
   logic [5:0]   bidx;
   logic [3:0]   rc_idx;
   logic [2:0]   osel;
   logic [9:0]   nbits;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {5'd0, oidx_ff, oword_ff};
   assign rsp_tlast  = olast_ff;

   assign cnt_sat = (req_tdata[67:64] > 4'd8) ? 4'd8 : req_tdata[67:64];
   assign room    = 7'd64 - fill_ff;
   assign nput    = ({3'd0, rem_ff} < room) ? rem_ff : room[3:0];
   assign rc_idx  = step_ff[4:1] - 4'd1;
   assign nw      = mode_ff ? 4'd4 : 4'd8;
   assign osel    = (mode_ff ? 3'd4 : 3'd0) + ocnt_ff[2:0];
   assign nbits   = (job_ff == JOB_BLK) ? 10'd512 : {fill_ff[6:0], 3'd0};

   always_comb begin
      padded = '0;
      for (int b = 0; b < 64; b++) begin
         if (7'(b) < fill_ff) begin
            padded[8*b +: 8] = buf_ff[8*b +: 8];
         end else if (7'(b) == fill_ff) begin
            padded[8*b +: 8] = 8'h01;
         end
      end
   end

   always_comb begin
      if (step_ff == '0) begin
         lps_arg = cv_ff ^ ((job_ff == JOB_BLK || job_ff == JOB_PAD) ? n_ff : '0);
      end else if (step_ff[0]) begin
         lps_arg = st_ff ^ k_ff;
      end else begin
         lps_arg = k_ff ^ ((rc_idx < 4'(ROUNDS)) ? RCONST[rc_idx] : '0);
      end
   end

   assign lps_res = sbg_lps(lps_arg);
   assign n_sum   = n_ff + {502'd0, nbits};
   assign cv_fin  = cv_ff ^ st_ff ^ k_ff ^ m_ff;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      step_in   = step_ff;
      mode_in   = csr_wr_en ? csr_wr_data : mode_ff;
      in_msg_in = in_msg_ff;
      fill_in   = fill_ff;
      hold_in   = hold_ff;
      rem_in    = rem_ff;
      last_in   = last_ff;
      cv_in     = cv_ff;
      n_in      = n_ff;
      s_in      = s_ff;
      buf_in    = buf_ff;
      m_in      = m_ff;
      k_in      = k_ff;
      st_in     = st_ff;
      ocnt_in   = ocnt_ff;
      ovld_in   = ovld_ff & ~rsp_tready;
      oword_in  = oword_ff;
      oidx_in   = oidx_ff;
      olast_in  = olast_ff;
      bidx      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               hold_in  = req_tdata[63:0];
               rem_in   = cnt_sat;
               last_in  = req_tlast;
               state_in = ST_PUT;
               if (!in_msg_ff) begin
                  in_msg_in = 1'b1;
                  cv_in     = mode_ff ? {64{8'h01}} : '0;
                  n_in      = '0;
                  s_in      = '0;
                  fill_in   = '0;
               end
            end
         end
         ST_PUT: begin
            for (int i = 0; i < 8; i++) begin
               bidx = fill_ff[5:0] + 6'(i);
               if (4'(i) < nput) begin
                  buf_in[8*bidx +: 8] = hold_ff[8*i +: 8];
               end
            end
            fill_in = fill_ff + {3'd0, nput};
            hold_in = hold_ff >> {nput, 3'd0};
            rem_in  = rem_ff - nput;
            if (fill_in == 7'd64) begin
               m_in     = buf_in;
               job_in   = JOB_BLK;
               step_in  = '0;
               st_in    = buf_in;
               state_in = ST_CMP;
            end else if (rem_in == 4'd0) begin
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            m_in     = padded;
            st_in    = padded;
            job_in   = JOB_PAD;
            step_in  = '0;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (step_ff != STEP_DONE) begin
               if (step_ff != '0 && step_ff[0]) begin
                  st_in = lps_res;
               end else begin
                  k_in = lps_res;
               end
               step_in = step_ff + 1'b1;
            end else begin
               cv_in   = cv_fin;
               step_in = '0;
               case (job_ff)
                  JOB_BLK: begin
                     n_in     = n_sum;
                     s_in     = s_ff + m_ff;
                     fill_in  = '0;
                     state_in = ST_PUT;
                  end
                  JOB_PAD: begin
                     n_in   = n_sum;
                     s_in   = s_ff + m_ff;
                     fill_in = '0;
                     m_in   = n_sum;
                     st_in  = n_sum;
                     job_in = JOB_FINN;
                  end
                  JOB_FINN: begin
                     m_in   = s_ff;
                     st_in  = s_ff;
                     job_in = JOB_FINS;
                  end
                  default: begin
                     in_msg_in = 1'b0;
                     ocnt_in   = '0;
                     state_in  = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!ovld_ff || rsp_tready) begin
               ovld_in  = 1'b1;
               oword_in = cv_ff[64*osel +: 64];
               oidx_in  = ocnt_ff[2:0];
               olast_in = (ocnt_ff + 4'd1 == nw);
               ocnt_in  = ocnt_ff + 4'd1;
               if (ocnt_ff + 4'd1 == nw) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= 1'b0;
         in_msg_ff <= 1'b0;
         fill_ff   <= '0;
         ovld_ff   <= 1'b0;
         step_ff   <= '0;
         job_ff    <= JOB_BLK;
         ocnt_ff   <= '0;
         rem_ff    <= '0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         in_msg_ff <= in_msg_in;
         fill_ff   <= fill_in;
         ovld_ff   <= ovld_in;
         step_ff   <= step_in;
         job_ff    <= job_in;
         ocnt_ff   <= ocnt_in;
         rem_ff    <= rem_in;
         last_ff   <= last_in;
      end
      hold_ff  <= hold_in;
      cv_ff    <= cv_in;
      n_ff     <= n_in;
      s_ff     <= s_in;
      buf_ff   <= buf_in;
      m_ff     <= m_in;
      k_ff     <= k_in;
      st_ff    <= st_in;
      oword_ff <= oword_in;
      oidx_ff  <= oidx_in;
      olast_ff <= olast_in;
   end

endmodule

### dv/streebog_hash_checker.sv
// Checker for the Streebog hash engine: watches both streams, predicts digests.
// Keeps its own chaining value, bit counter, block sum and block buffer.
// Depends on sbg_pkg (S-box, linear map rows, round constants).
`timescale 1ns / 100ps
module streebog_hash_checker
   import sbg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_words
);

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_slice_type;

   digest_slice_type digest_queue[$];
   logic [511:0]  chain_h, bit_count_n, sigma_sum, block_buf;
   logic [6:0]    fill;
   logic          mid_message;
   logic          mode_256;

   function automatic logic [511:0] lps_round(input logic [511:0] w);
      logic [511:0] t;
      logic [63:0]  v, r;
      for (int i = 0; i < 8; i++) begin
         for (int k = 0; k < 8; k++) v[8*k +: 8] = SBOX[w[64*k + 8*i +: 8]];
         r = '0;
         for (int b = 0; b < 64; b++) if (v[b]) r ^= LMAT[63-b];
         t[64*i +: 64] = r;
      end
      return t;
   endfunction

   function automatic logic [511:0] g_compress(input logic [511:0] h, nv, m);
      logic [511:0] k, st;
      k  = lps_round(h ^ nv);
      st = m;
      for (int i = 0; i < ROUNDS; i++) begin
         st = lps_round(st ^ k);
         k  = lps_round(k ^ RCONST[i]);
      end
      return h ^ st ^ k ^ m;
   endfunction

   task automatic absorb_block(input logic [511:0] m, input logic [63:0] bits);
      chain_h     = g_compress(chain_h, bit_count_n, m);
      bit_count_n = bit_count_n + {448'd0, bits};
      sigma_sum   = sigma_sum + m;
   endtask

   task automatic hash_word(input logic [63:0] data, input logic [3:0] cnt_in,
                            input logic is_last);
      int cnt;
      int nw;
      digest_slice_type s;
      cnt = (cnt_in > 4'd8) ? 8 : int'(cnt_in);
      if (!mid_message) begin
         chain_h     = mode_256 ? {64{8'h01}} : '0;
         bit_count_n = '0;
         sigma_sum   = '0;
         fill        = '0;
         mid_message = 1'b1;
      end
      for (int i = 0; i < cnt; i++) begin
         block_buf[8*fill +: 8] = data[8*i +: 8];
         fill++;
         if (fill >= 7'd64) begin
            absorb_block(block_buf, 64'd512);
            fill = '0;
         end
      end
      if (is_last) begin
         for (int i = 0; i < 64; i++) if (i >= fill) block_buf[8*i +: 8] = 8'h00;
         block_buf[8*fill[5:0] +: 8] = 8'h01;
         absorb_block(block_buf, 64'(fill) * 8);
         chain_h     = g_compress(chain_h, '0, bit_count_n);
         chain_h     = g_compress(chain_h, '0, sigma_sum);
         mid_message = 1'b0;
         fill        = '0;
         nw = mode_256 ? 4 : 8;
         for (int i = 0; i < nw; i++) begin
            s.digest_word = chain_h[64*(8-nw+i) +: 64];
            s.word_index  = 3'(i);
            s.last_word   = (i + 1 == nw);
            digest_queue.push_back(s);
         end
      end
   endtask

   always @(posedge clock) begin
      digest_slice_type exp_s;
      if (reset) begin
         mode_256    = 1'b0;
         mid_message = 1'b0;
         fill        = '0;
         digest_queue.delete();
         fail_count    <= 0;
         pending_words <= 0;
      end else begin
         if (csr_wr_en) mode_256 = csr_wr_data;
         if (req_tvalid && req_tready)
            hash_word(req_tdata[63:0], req_tdata[67:64], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                        rsp_tdata[63:0], rsp_tdata[66:64], rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               exp_s = digest_queue.pop_front();
               if (rsp_tdata[63:0] !== exp_s.digest_word
                   || rsp_tdata[66:64] !== exp_s.word_index
                   || rsp_tlast !== exp_s.last_word || rsp_tdata[71:67] !== '0) begin
                  $display("%0t: digest mismatch: expected %h idx %0d last %0b,",
                           $time, exp_s.digest_word, exp_s.word_index,
                           exp_s.last_word,
                           " got %h idx %0d last %0b",
                           rsp_tdata[63:0], rsp_tdata[66:64], rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_words <= digest_queue.size();
      end
   end

endmodule

### dv/testbench.sv
// Testbench top for streebog_hash_engine_unit: clock, reset, message stimulus.
// Drives directed then random messages in both digest modes, with random gaps.
// Depends on streebog_hash_checker and the engine RTL.
`timescale 1ns / 100ps
module testbench;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic        csr_wr_data = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending_words;
   int          words_sent = 0;
   int          rsp_gap = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   streebog_hash_engine_unit DUT (.*);
   streebog_hash_checker checker_i (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else if (rsp_gap != 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= rsp_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= gap_len();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_word(input logic [63:0] data, input logic [3:0] cnt,
                            input logic is_last, input bit no_gap);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, cnt, data};
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   task automatic drain_and_set_mode(input logic m);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random message of n bytes total (more when a final count of 9 to 15 saturates to 8), split into random-sized words
   task automatic send_message(input int nbytes);
      int left, c;
      left = nbytes;
      while (left > 8) begin
         c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 8;
         if (c == 0) c = 1;
         send_word(rand64(), 4'(c), 1'b0, 1'b0);
         left -= c;
      end
      c = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : left;
      send_word(rand64(), 4'(c), 1'b1, 1'b0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty message, extremes, special cases
      send_word('0, 4'd0, 1'b1, 1'b0);
      send_word('1, 4'd8, 1'b1, 1'b0);
      send_word(64'h0123456789abcdef, 4'd15, 1'b1, 1'b0);
      send_word(64'hffffffffffffff00, 4'd1, 1'b0, 1'b0);
      send_word(64'h5555aaaa5555aaaa, 4'd0, 1'b0, 1'b0);
      send_word(64'haaaa5555aaaa5555, 4'd3, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) send_word(rand64(), 4'd8, i == 7, 1'b0);
      drain_and_set_mode(1'b1);
      send_word('1, 4'd8, 1'b1, 1'b0);
      for (int i = 0; i < 9; i++) send_word(rand64(), 4'd8, 1'b0, 1'b0);
      send_word(rand64(), 4'd0, 1'b1, 1'b0);
      drain_and_set_mode(1'b0);
      // random part
      while (words_sent < 240) begin
         if ($urandom_range(0, 7) == 0) drain_and_set_mode(1'($urandom_range(0, 1)));
         case ($urandom_range(0, 3))
            0: send_message($urandom_range(0, 16));
            1: send_message(64 * $urandom_range(1, 2));
            default: send_message($urandom_range(0, 200));
         endcase
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("** streebog_hash_engine_unit: PASSED **");
      else
         $display("** streebog_hash_engine_unit: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("** streebog_hash_engine_unit: FAILED **");
      $finish;
   end

endmodule

### files.f
design/sbg_pkg.sv
design/streebog_hash_engine_unit.sv
dv/streebog_hash_checker.sv
dv/testbench.sv
